@@ hdl/dtyp_pkg.sv @@
package dtyp_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int ITER_DEF        = 24;
    localparam int MAX_ITER        = 32;

    // Datapath width for scaled coordinates and angle accumulator width (Q24 degrees).
    localparam int DW = 40;
    localparam int AW = 35;

    localparam logic [23:0] KINV_Q24        = 24'd10188014;
    localparam logic [63:0] DEG_PER_RAD_Q24 = 64'd961263669;
    localparam logic signed [AW-1:0] HALF_TURN_Q24 = AW'(64'd180 * 64'd16777216);
    localparam logic signed [AW-1:0] FULL_TURN_Q16 = AW'(64'd360 * 64'd65536);
    localparam logic signed [AW-1:0] QUARTER_Q16   = AW'(64'd90 * 64'd65536);
    localparam logic signed [AW-1:0] ROUND_Q24     = AW'(128);

    typedef struct packed {
        logic                 undef;
        logic                 pzero;
        logic signed [AW-1:0] a;
        logic signed [DW-1:0] w;
    } side_t;

    typedef struct packed {
        logic               undef;
        logic signed [23:0] pitch;
        logic [24:0]        yaw;
    } res_t;

    function automatic logic signed [AW-1:0] micro_angle(input int i);
        logic [63:0] t;
        begin
            t = 64'd0;
            unique case (i)
                0: t = 64'd754974720;
                1: t = 64'd445687602;
                2: t = 64'd235489088;
                3: t = 64'd119537938;
                4: t = 64'd60000934;
                5: t = 64'd30029717;
                6: t = 64'd15018523;
                7: t = 64'd7509720;
                8: t = 64'd3754917;
                9: t = 64'd1877466;
                default: t = (DEG_PER_RAD_Q24 + (64'd1 << (i - 1))) >> i;
            endcase
            return t[AW-1:0];
        end
    endfunction

endpackage

@@ hdl/direction_to_yaw_pitch.sv @@
// Registers in order: prep, yaw CORDIC, multiplier, pitch CORDIC, result, output.
// Throughput: one transaction per cycle unless stalled; the CORDIC stages are unrolled.
// The pipeline advances as a whole whenever the output skid register is empty.
// Reset is asynchronous and active low; it clears every valid bit, data is not reset.
module direction_to_yaw_pitch #(
    parameter int COORD_WIDTH       = dtyp_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_ITERATIONS = dtyp_pkg::ITER_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // x_coord, y_coord, z_coord
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // yaw_degrees, pitch_degrees, zero padding
    output logic        m_tuser    // yaw_undefined
);
    import dtyp_pkg::*;

    localparam int N  = CORDIC_ITERATIONS;
    localparam int CB = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int SH = 32 - CB;

    logic en;
    logic signed [31:0] xs, ys, zs;
    logic signed [DW-1:0] x16, y16, z16, u0, v0;
    logic signed [AW-1:0] base0;
    logic undef0;

    logic                 prep_valid_reg;
    logic signed [DW-1:0] prep_u_reg, prep_v_reg;
    logic signed [AW-1:0] prep_ang_reg;
    side_t                prep_side_reg, prep_side_next;

    logic                 yv [0:N];
    logic signed [DW-1:0] yu [0:N];
    logic signed [DW-1:0] yvv [0:N];
    logic signed [AW-1:0] ya [0:N];
    side_t                ys_side [0:N];

    logic                 pv [0:N];
    logic signed [DW-1:0] pu [0:N];
    logic signed [DW-1:0] pvv [0:N];
    logic signed [AW-1:0] pa [0:N];
    side_t                ps_side [0:N];

    logic signed [DW-1:0] rho;
    side_t                mside;
    logic                 mvalid;

    logic signed [AW-1:0] yaw_q, pitch_q;
    res_t                 fin_next, fin_reg, out_res;
    logic                 fin_valid_reg;

    always_comb
    begin
        xs  = $signed(s_tdata[31:0] << SH) >>> SH;
        ys  = $signed(s_tdata[63:32] << SH) >>> SH;
        zs  = $signed(s_tdata[95:64] << SH) >>> SH;
        x16 = {{(DW-36){xs[31]}}, xs, 4'd0};
        y16 = {{(DW-36){ys[31]}}, ys, 4'd0};
        z16 = {{(DW-36){zs[31]}}, zs, 4'd0};
        undef0 = (x16 == '0) && (y16 == '0);
        u0    = -y16;
        v0    = x16;
        base0 = '0;
        if (undef0)
        begin
            u0 = '0;
            v0 = '0;
        end
        else if (u0[DW-1])
        begin
            u0    = y16;
            v0    = -x16;
            base0 = HALF_TURN_Q24;
        end
        prep_side_next.undef = undef0;
        prep_side_next.pzero = 1'b0;
        prep_side_next.a     = '0;
        prep_side_next.w     = z16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prep_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_u_reg    <= u0;
            prep_v_reg    <= v0;
            prep_ang_reg  <= base0;
            prep_side_reg <= prep_side_next;
        end
    end

    assign yv[0]      = prep_valid_reg;
    assign yu[0]      = prep_u_reg;
    assign yvv[0]     = prep_v_reg;
    assign ya[0]      = prep_ang_reg;
    assign ys_side[0] = prep_side_reg;

    for (genvar g = 0; g < N; g++)
    begin : g_yaw
        dtyp_vec_stage #(.IDX(g)) u_stage (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(yv[g]), .in_u(yu[g]), .in_v(yvv[g]), .in_ang(ya[g]),
            .in_side(ys_side[g]),
            .out_valid(yv[g+1]), .out_u(yu[g+1]), .out_v(yvv[g+1]), .out_ang(ya[g+1]),
            .out_side(ys_side[g+1])
        );
    end

    dtyp_rho_mult u_mult (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(yv[N]), .in_u(yu[N]), .in_ang(ya[N]), .in_side(ys_side[N]),
        .out_valid(mvalid), .out_rho(rho), .out_side(mside)
    );

    assign pv[0]      = mvalid;
    assign pu[0]      = rho;
    assign pvv[0]     = mside.w;
    assign pa[0]      = '0;
    assign ps_side[0] = mside;

    for (genvar g = 0; g < N; g++)
    begin : g_pitch
        dtyp_vec_stage #(.IDX(g)) u_stage (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(pv[g]), .in_u(pu[g]), .in_v(pvv[g]), .in_ang(pa[g]),
            .in_side(ps_side[g]),
            .out_valid(pv[g+1]), .out_u(pu[g+1]), .out_v(pvv[g+1]), .out_ang(pa[g+1]),
            .out_side(ps_side[g+1])
        );
    end

    always_comb
    begin
        yaw_q   = (ps_side[N].a + ROUND_Q24) >>> 8;
        pitch_q = (pa[N] + ROUND_Q24) >>> 8;
        if (yaw_q < 0)
        begin
            yaw_q = yaw_q + FULL_TURN_Q16;
        end
        if (yaw_q >= FULL_TURN_Q16)
        begin
            yaw_q = yaw_q - FULL_TURN_Q16;
        end
        if (pitch_q > QUARTER_Q16)
        begin
            pitch_q = QUARTER_Q16;
        end
        if (pitch_q < -QUARTER_Q16)
        begin
            pitch_q = -QUARTER_Q16;
        end
        fin_next.undef = ps_side[N].undef;
        fin_next.yaw   = ps_side[N].undef ? 25'd0 : yaw_q[24:0];
        fin_next.pitch = ps_side[N].pzero ? 24'sd0 : pitch_q[23:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_valid_reg <= pv[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_reg <= fin_next;
        end
    end

    dtyp_out_buf u_out (
        .clk(clk), .rst_n(rst_n),
        .push(en && fin_valid_reg), .push_data(fin_reg), .ready(en),
        .out_valid(m_tvalid), .out_data(out_res), .out_ready(m_tready)
    );

    assign s_tready = en;
    assign m_tdata  = {7'd0, out_res.pitch, out_res.yaw};
    assign m_tuser  = out_res.undef;

    a_undef_yaw_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[24:0] == 25'd0)
        else $error("Yaw is not zero for an undefined direction.");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[48:25]) <= 24'sd5898240 &&
                      $signed(m_tdata[48:25]) >= -24'sd5898240))
        else $error("Pitch is outside plus or minus ninety degrees.");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[24:0] <= 25'd23592959)
        else $error("Yaw is outside the full turn.");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("Input stalled while the output register is empty.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("Input stalled without an output stall.");

endmodule

@@ hdl/dtyp_vec_stage.sv @@
module dtyp_vec_stage #(
    parameter int IDX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [dtyp_pkg::DW-1:0] in_u,
    input  logic signed [dtyp_pkg::DW-1:0] in_v,
    input  logic signed [dtyp_pkg::AW-1:0] in_ang,
    input  dtyp_pkg::side_t               in_side,
    output logic                          out_valid,
    output logic signed [dtyp_pkg::DW-1:0] out_u,
    output logic signed [dtyp_pkg::DW-1:0] out_v,
    output logic signed [dtyp_pkg::AW-1:0] out_ang,
    output dtyp_pkg::side_t               out_side
);
    import dtyp_pkg::*;

    localparam logic signed [AW-1:0] MA = micro_angle(IDX);

    logic                 valid_reg;
    logic signed [DW-1:0] u_reg, u_next, v_reg, v_next, du, dv;
    logic signed [AW-1:0] ang_reg, ang_next;
    side_t                side_reg;

    always_comb
    begin
        du = in_v >>> IDX;
        dv = in_u >>> IDX;
        if (!in_v[DW-1])
        begin
            u_next   = in_u + du;
            v_next   = in_v - dv;
            ang_next = in_ang + MA;
        end
        else
        begin
            u_next   = in_u - du;
            v_next   = in_v + dv;
            ang_next = in_ang - MA;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg    <= u_next;
            v_reg    <= v_next;
            ang_reg  <= ang_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_u     = u_reg;
    assign out_v     = v_reg;
    assign out_ang   = ang_reg;
    assign out_side  = side_reg;

endmodule

@@ hdl/dtyp_rho_mult.sv @@
module dtyp_rho_mult (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [dtyp_pkg::DW-1:0] in_u,
    input  logic signed [dtyp_pkg::AW-1:0] in_ang,
    input  dtyp_pkg::side_t               in_side,
    output logic                          out_valid,
    output logic signed [dtyp_pkg::DW-1:0] out_rho,
    output dtyp_pkg::side_t               out_side
);
    import dtyp_pkg::*;

    logic [37:0]          u_pos;
    logic [42:0]          p_lo_next, p_hi_next;
    logic [42:0]          p_lo_reg, p_hi_reg;
    logic                 va_reg, vb_reg;
    side_t                sa_reg, sa_next, sb_reg, sb_next;
    logic [61:0]          full;
    logic signed [DW-1:0] rho_next, rho_reg;

    always_comb
    begin
        u_pos = in_u[DW-1] ? 38'd0 : in_u[37:0];
        p_lo_next = 43'(u_pos[18:0]) * 43'(KINV_Q24);
        p_hi_next = 43'(u_pos[37:19]) * 43'(KINV_Q24);
        sa_next   = in_side;
        sa_next.a = in_ang;
    end

    always_comb
    begin
        full     = {p_hi_reg, 19'd0} + 62'(p_lo_reg);
        rho_next = DW'(full[61:24]);
        sb_next       = sa_reg;
        sb_next.pzero = (full[61:24] == 38'd0) && (sa_reg.w == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_lo_reg <= p_lo_next;
            p_hi_reg <= p_hi_next;
            sa_reg   <= sa_next;
            rho_reg  <= rho_next;
            sb_reg   <= sb_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_rho   = rho_reg;
    assign out_side  = sb_reg;

endmodule

@@ hdl/dtyp_out_buf.sv @@
module dtyp_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dtyp_pkg::res_t  push_data,
    output logic            ready,
    output logic            out_valid,
    output dtyp_pkg::res_t  out_data,
    input  logic            out_ready
);
    import dtyp_pkg::*;

    logic out_valid_reg, skid_valid_reg;
    res_t out_reg, skid_reg;
    logic pop;

    assign pop = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

    assign ready     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
